### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands, sampled on clock, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define UTF8D_ASSERT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UTF8D_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// shared types, constants and byte-class helpers of the lenient utf-8 decoder
// ----------------------------------------------------------------------------
package utf8d_pkg;

   localparam int unsigned CpWidth  = 31;
   localparam int unsigned CntWidth = 3;

   localparam logic [CpWidth-1:0] SubstChar = 31'd63;

   // results one input word leaves behind: a run of replacements, then
   // optionally one final character
   typedef struct packed {
      logic [CntWidth-1:0] rep_count;
      logic                final_valid;
      logic [CpWidth-1:0]  final_cp;
      logic [CntWidth-1:0] final_count;
      logic                final_rep;
   } job_type;

   function automatic logic [CntWidth-1:0] trail_count(input logic [7:0] b);
      logic [CntWidth-1:0] t;
      if (b < 8'hC0)      t = 3'd0;
      else if (b < 8'hE0) t = 3'd1;
      else if (b < 8'hF0) t = 3'd2;
      else if (b < 8'hF8) t = 3'd3;
      else if (b < 8'hFC) t = 3'd4;
      else                t = 3'd5;
      return t;
   endfunction

   function automatic logic [7:0] lead_mask(input logic [CntWidth-1:0] t);
      logic [7:0] m;
      case (t)
         3'd0:    m = 8'h7F;
         3'd1:    m = 8'h1F;
         3'd2:    m = 8'h0F;
         3'd3:    m = 8'h07;
         3'd4:    m = 8'h03;
         default: m = 8'h01;
      endcase
      return m;
   endfunction

endpackage

### rtl/core/utf8d_decode.sv
// ----------------------------------------------------------------------------
// utf8d_decode
// sequence state and per-word decode into a job of pending results
// ----------------------------------------------------------------------------
module utf8d_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          in_byte,
   input  logic                end_of_text,
   input  logic                accept,
   output utf8d_pkg::job_type  job_out
);

   logic [utf8d_pkg::CpWidth-1:0]  acc_ff, acc_in;
   logic [utf8d_pkg::CntWidth-1:0] cnt_ff, cnt_in;
   logic [utf8d_pkg::CntWidth-1:0] texp_ff, texp_in;
   logic [utf8d_pkg::CpWidth-1:0]  acc_shift;
   logic [utf8d_pkg::CntWidth-1:0] trail;
   logic                           is_cont;
   logic                           fresh;
   utf8d_pkg::job_type             job;

   assign is_cont   = (in_byte[7:6] == 2'b10);
   assign trail     = utf8d_pkg::trail_count(in_byte);
   assign acc_shift = {acc_ff[utf8d_pkg::CpWidth-7:0], in_byte[5:0]};

   always_comb begin
      job     = '0;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      texp_in = texp_ff;
      fresh   = 1'b1;

      if (cnt_ff != '0) begin
         if (is_cont) begin
            fresh = 1'b0;
            if (cnt_ff >= texp_ff) begin
               job.final_valid = 1'b1;
               job.final_cp    = acc_shift;
               job.final_count = cnt_ff + 3'd1;
               job.final_rep   = 1'b0;
               acc_in          = '0;
               cnt_in          = '0;
               texp_in         = '0;
            end else if (end_of_text) begin
               job.rep_count = cnt_ff + 3'd1;
            end else begin
               acc_in = acc_shift;
               cnt_in = cnt_ff + 3'd1;
            end
         end else begin
            // broken sequence
            job.rep_count = cnt_ff;
            acc_in        = '0;
            cnt_in        = '0;
            texp_in       = '0;
         end
      end

      if (fresh) begin
         if (trail == '0) begin
            job.final_valid = 1'b1;
            job.final_count = 3'd1;
            if (in_byte[7]) begin
               job.final_cp  = utf8d_pkg::SubstChar;
               job.final_rep = 1'b1;
            end else begin
               job.final_cp  = {23'd0, in_byte};
               job.final_rep = 1'b0;
            end
         end else if (end_of_text) begin
            job.final_valid = 1'b1;
            job.final_count = 3'd1;
            job.final_cp    = utf8d_pkg::SubstChar;
            job.final_rep   = 1'b1;
         end else begin
            acc_in  = {23'd0, in_byte & utf8d_pkg::lead_mask(trail)};
            cnt_in  = 3'd1;
            texp_in = trail;
         end
      end

      if (end_of_text) begin
         acc_in  = '0;
         cnt_in  = '0;
         texp_in = '0;
      end
   end

   assign job_out = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         cnt_ff  <= '0;
         texp_ff <= '0;
      end else if (accept) begin
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         texp_ff <= texp_in;
      end
   end

endmodule

### rtl/core/utf8d_emit.sv
// ----------------------------------------------------------------------------
// utf8d_emit
// job register and result register; unrolls one job into result words
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8d_emit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 job_load,
   input  utf8d_pkg::job_type                   job_in,
   output logic                                 busy,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [utf8d_pkg::CpWidth-1:0]        rsp_code_point,
   output logic [utf8d_pkg::CntWidth-1:0]       rsp_byte_count,
   output logic                                 rsp_is_replacement,
   output logic                                 rsp_last_of_run
);

   utf8d_pkg::job_type                   job_ff, job_nx_in;
   logic                                 job_v_ff, job_v_in;
   logic                                 out_v_ff, out_v_in;
   logic [utf8d_pkg::CpWidth-1:0]        cp_ff, cp_in;
   logic [utf8d_pkg::CntWidth-1:0]       cnt_ff, cnt_in;
   logic                                 rep_ff, rep_in;
   logic                                 last_ff, last_in;
   logic                                 take;
   logic                                 job_empty;
   logic                                 job_last;

   assign take      = !out_v_ff || !rsp_stall;
   assign job_empty = !job_v_ff || (job_ff.rep_count == '0 && !job_ff.final_valid);
   assign job_last  = job_v_ff &&
                      ((job_ff.rep_count == 3'd1 && !job_ff.final_valid) ||
                       (job_ff.rep_count == '0 && job_ff.final_valid));
   assign busy      = !job_empty && !(take && job_last);

   always_comb begin
      out_v_in  = out_v_ff;
      cp_in     = cp_ff;
      cnt_in    = cnt_ff;
      rep_in    = rep_ff;
      last_in   = last_ff;
      job_nx_in = job_ff;
      job_v_in  = job_v_ff;

      if (take) begin
         out_v_in = 1'b0;
         if (job_v_ff && job_ff.rep_count != '0) begin
            out_v_in            = 1'b1;
            cp_in               = utf8d_pkg::SubstChar;
            cnt_in              = 3'd1;
            rep_in              = 1'b1;
            last_in             = job_last;
            job_nx_in.rep_count = job_ff.rep_count - 3'd1;
         end else if (job_v_ff && job_ff.final_valid) begin
            out_v_in              = 1'b1;
            cp_in                 = job_ff.final_cp;
            cnt_in                = job_ff.final_count;
            rep_in                = job_ff.final_rep;
            last_in               = 1'b1;
            job_nx_in.final_valid = 1'b0;
         end
      end

      if (job_load) begin
         job_nx_in = job_in;
         job_v_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         job_v_ff <= job_v_in;
         out_v_ff <= out_v_in;
      end
      job_ff  <= job_nx_in;
      cp_ff   <= cp_in;
      cnt_ff  <= cnt_in;
      rep_ff  <= rep_in;
      last_ff <= last_in;
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_code_point     = cp_ff;
   assign rsp_byte_count     = cnt_ff;
   assign rsp_is_replacement = rep_ff;
   assign rsp_last_of_run    = last_ff;

   `UTF8D_ASSERT(a_no_overwrite, job_load, job_empty || (take && job_last), "job overwritten")
   `UTF8D_ASSERT_NEXT(a_rep_countdown, job_v_ff && job_ff.rep_count != '0 && take && !job_load, job_ff.rep_count == $past(job_ff.rep_count) - 3'd1, "bad countdown")
   `UTF8D_ASSERT(a_char_is_last, out_v_ff && !rep_ff, last_ff, "character not last of run")
   `UTF8D_ASSERT(a_rep_single_byte, out_v_ff && rep_ff, cnt_ff == 3'd1 && cp_ff == utf8d_pkg::SubstChar, "bad replacement")

endmodule

### rtl/core/utf8_lenient_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_lenient_decoder_core
// lenient utf-8 decoder, sequences up to six bytes, '?' per bad byte
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_in_byte, req_end_of_text
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_code_point, rsp_byte_count,
//           |           |                      | rsp_is_replacement, rsp_last_of_run
//
// one word accepted per cycle while req_stall is low; the job for a character's
// last byte loads the job register on the accepting edge, and the result
// register takes the character from there once rsp_stall and any pending replacements allow
// a word that yields several results holds req_stall while the single result
// register drains the job one result a cycle, when rsp_stall does not hold it
// rsp_stall backs up into req_stall once the job register is occupied
// synchronous reset clears the sequence state and both valid flags
// ----------------------------------------------------------------------------
module utf8_lenient_decoder_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_in_byte,
   input  logic                            req_end_of_text,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [utf8d_pkg::CpWidth-1:0]   rsp_code_point,
   output logic [utf8d_pkg::CntWidth-1:0]  rsp_byte_count,
   output logic                            rsp_is_replacement,
   output logic                            rsp_last_of_run
);

   utf8d_pkg::job_type job;
   logic               accept;
   logic               busy;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   utf8d_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .in_byte     (req_in_byte),
      .end_of_text (req_end_of_text),
      .accept      (accept),
      .job_out     (job)
   );

   utf8d_emit u_emit (
      .clock              (clock),
      .reset              (reset),
      .job_load           (accept),
      .job_in             (job),
      .busy               (busy),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_code_point     (rsp_code_point),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_is_replacement (rsp_is_replacement),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule
